>>> sv/blp_pkg.sv
package blp_pkg;

  // Coordinate and grid widths
  localparam int unsigned GridSize = 64;
  localparam int unsigned CoordW   = $clog2(GridSize);
  localparam int unsigned GridW    = CoordW + 1;
  localparam int unsigned ValueW   = 32;

  // Arithmetic widths of the stepping datapath
  localparam int unsigned MinorW   = CoordW + 1;
  localparam int unsigned DecW     = CoordW + 4;
  localparam int unsigned IncEW    = CoordW + 1;
  localparam int unsigned IncNeW   = CoordW + 2;

  // Configuration register indexes
  localparam logic RegGridRows = 1'b0;
  localparam logic RegGridCols = 1'b1;

  // One line request
  typedef struct packed {
    logic        [CoordW-1:0] start_row;
    logic        [CoordW-1:0] start_col;
    logic        [CoordW-1:0] end_row;
    logic        [CoordW-1:0] end_col;
    logic signed [ValueW-1:0] pixel_value;
  } line_req_t;

  // One pixel write
  typedef struct packed {
    logic        [CoordW-1:0] pix_row;
    logic        [CoordW-1:0] pix_col;
    logic signed [ValueW-1:0] pix_value;
    logic                     in_grid;
    logic                     last;
  } pixel_t;

  // Grid bounds handed from the register block to the core
  typedef struct packed {
    logic [GridW-1:0] rows;
    logic [GridW-1:0] cols;
  } grid_cfg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StSetup = 3'b010,
    StRun   = 3'b100
  } blp_state_e;

endpackage

>>> sv/bresenham_line_pixels_top.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_data_i  (line_req_t)
// out       output     out_valid_o / out_ready_i  out_data_o (pixel_t)
// config    input      APB psel/penable/pready    paddr, pwdata, prdata
//
// A line is latched on acceptance, set up in the StSetup state, then stepped at
// one pixel per cycle while the output register is empty or being drained.
// Input is refused until the last pixel of the line is loaded into the output
// register; a stalled output holds the stepping state in place.
// rst_ni clears the sequencer and output valid and sets both grid sizes to 64.
module bresenham_line_pixels_top import blp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  line_req_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pixel_t      out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [GridW-1:0] grid_rows_q;
  logic [GridW-1:0] grid_cols_q;
  logic             reg_sel;
  logic             wr_en;
  grid_cfg_t        grid;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Grid size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= GridW'(GridSize);
      grid_cols_q <= GridW'(GridSize);
    end else if (wr_en) begin
      if (reg_sel == RegGridRows) begin
        grid_rows_q <= pwdata[GridW-1:0];
      end else begin
        grid_cols_q <= pwdata[GridW-1:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      RegGridRows: prdata = 32'(grid_rows_q);
      RegGridCols: prdata = 32'(grid_cols_q);
      default:     prdata = '0;
    endcase
  end

  assign grid.rows = grid_rows_q;
  assign grid.cols = grid_cols_q;

  blp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grid_i      (grid),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sv/blp_core.sv
module blp_core import blp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  grid_cfg_t grid_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  line_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pixel_t    out_data_o
);

  blp_state_e state_q, state_d;

  line_req_t req_q;

  logic        [CoordW-1:0] major_pos_q, major_pos_d;
  logic        [CoordW-1:0] major_end_q, major_end_d;
  logic signed [MinorW-1:0] minor_pos_q, minor_pos_d;
  logic signed [DecW-1:0]   decision_q, decision_d;
  logic        [IncEW-1:0]  inc_east_q, inc_east_d;
  logic signed [IncNeW-1:0] inc_ne_q, inc_ne_d;
  logic                     swapped_q, swapped_d;
  logic                     flipped_q, flipped_d;

  logic   out_valid_q, out_valid_d;
  pixel_t out_q, out_d;

  // Setup terms
  logic [CoordW-1:0] d_row, d_col;
  logic              steep;
  logic [CoordW-1:0] a1, b1, a2, b2;
  logic [CoordW-1:0] lo_a, lo_b, hi_a, hi_b;
  logic              flip;
  logic [CoordW-1:0] dx, dy;

  // Step terms
  logic                     emit;
  logic                     is_last;
  logic signed [DecW-1:0]   step_inc;
  logic signed [MinorW-1:0] minor_out;
  logic [CoordW-1:0]        row_out, col_out;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Axis swap, endpoint ordering and minor mirroring of the latched request.
  always_comb begin
    d_row = (req_q.end_row >= req_q.start_row) ? req_q.end_row - req_q.start_row
                                               : req_q.start_row - req_q.end_row;
    d_col = (req_q.end_col >= req_q.start_col) ? req_q.end_col - req_q.start_col
                                               : req_q.start_col - req_q.end_col;
    steep = d_col > d_row;
    a1 = steep ? req_q.start_col : req_q.start_row;
    b1 = steep ? req_q.start_row : req_q.start_col;
    a2 = steep ? req_q.end_col   : req_q.end_row;
    b2 = steep ? req_q.end_row   : req_q.end_col;
    if (a1 > a2) begin
      lo_a = a2; lo_b = b2; hi_a = a1; hi_b = b1;
    end else begin
      lo_a = a1; lo_b = b1; hi_a = a2; hi_b = b2;
    end
    flip = lo_b > hi_b;
    dx   = hi_a - lo_a;
    dy   = flip ? lo_b - hi_b : hi_b - lo_b;
  end

  // Current pixel from the stepping state.
  always_comb begin
    minor_out = flipped_q ? -minor_pos_q : minor_pos_q;
    row_out   = swapped_q ? minor_out[CoordW-1:0] : major_pos_q;
    col_out   = swapped_q ? major_pos_q : minor_out[CoordW-1:0];
    is_last   = (major_pos_q == major_end_q);
    emit      = (state_q == StRun) && (!out_valid_q || out_ready_i);
    // One shared adder operand: east or northeast increment.
    step_inc  = (decision_q <= 0) ? DecW'($signed({1'b0, inc_east_q}))
                                  : DecW'(inc_ne_q);
  end

  // Sequencer: latch, set up, then one pixel per free output slot.
  always_comb begin
    state_d     = state_q;
    major_pos_d = major_pos_q;
    major_end_d = major_end_q;
    minor_pos_d = minor_pos_q;
    decision_d  = decision_q;
    inc_east_d  = inc_east_q;
    inc_ne_d    = inc_ne_q;
    swapped_d   = swapped_q;
    flipped_d   = flipped_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        swapped_d   = steep;
        flipped_d   = flip;
        major_pos_d = lo_a;
        major_end_d = hi_a;
        minor_pos_d = flip ? -$signed({1'b0, lo_b}) : $signed({1'b0, lo_b});
        decision_d  = $signed({3'b000, dy, 1'b0}) - $signed({4'b0000, dx});
        inc_east_d  = {dy, 1'b0};
        inc_ne_d    = $signed({1'b0, dy, 1'b0}) - $signed({1'b0, dx, 1'b0});
        state_d     = StRun;
      end
      StRun: begin
        if (emit) begin
          out_valid_d       = 1'b1;
          out_d.pix_row     = row_out;
          out_d.pix_col     = col_out;
          out_d.pix_value   = req_q.pixel_value;
          out_d.in_grid     = ({1'b0, row_out} < grid_i.rows) &&
                              ({1'b0, col_out} < grid_i.cols);
          out_d.last        = is_last;
          if (is_last) begin
            state_d = StIdle;
          end else begin
            decision_d  = decision_q + step_inc;
            major_pos_d = major_pos_q + CoordW'(1);
            if (decision_q > 0) begin
              minor_pos_d = minor_pos_q + MinorW'(1);
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    major_pos_q <= major_pos_d;
    major_end_q <= major_end_d;
    minor_pos_q <= minor_pos_d;
    decision_q  <= decision_d;
    inc_east_q  <= inc_east_d;
    inc_ne_q    <= inc_ne_d;
    swapped_q   <= swapped_d;
    flipped_q   <= flipped_d;
    out_q       <= out_d;
  end

endmodule

>>> sv/blp_checker.sv
module blp_checker import blp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input pixel_t    out_data_o
);

  // A stalled pixel stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled pixel changed");

  // Once a line is taken, no new request is taken in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while a line is in progress");

  // A pending pixel that is not the last one means the line is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("ready while a line is unfinished");

  // Pixels of one line that are handed over back to back carry the same value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last ##1 out_valid_o
      |-> out_data_o.pix_value == $past(out_data_o.pix_value))
    else $error("pixel value changed within a line");

endmodule

bind bresenham_line_pixels_top blp_checker u_blp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
